@@ rtl/mwie_pkg.sv @@
package mwie_pkg;

  localparam int CHUNK_BYTES     = 4;
  localparam int CHUNK_W         = 8 * CHUNK_BYTES;
  localparam int INDEX_W         = 16;
  localparam int WPC_W           = 4;
  localparam int MAX_WORDS       = 8;
  localparam int COUNT_W         = $clog2(MAX_WORDS + 1);

  localparam logic [INDEX_W-1:0] LIST_LENGTH_RST = 16'd1626;
  localparam logic [WPC_W-1:0]   WORD_COUNT_RST  = 4'd3;

  localparam int CMD_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  typedef enum logic [0:0] {
    CFG_LIST_LENGTH = 1'b0,
    CFG_WORD_COUNT  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_word;
    logic               chunk_last;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] word_index;
    logic               last_of_chunk;
    logic               last_of_phrase;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_word;
    logic               chunk_last;
    logic [INDEX_W-1:0] modulus;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

@@ rtl/mnemonic_word_index_encoder_unit.sv @@
// Mnemonic word index encoder. Each input transaction carries a 32-bit
// little-endian key chunk; the block returns list_length-based word indices
// for it, as many as the configured word count (clamped to 1..8), each index
// being (chunk / list_length^k + previous index) mod list_length. For each chunk
// the back end picks up the command, then per word runs a shared radix-4
// restoring divider (quotient and remainder by list_length) and then forms
// and queues the index, holding while the output queue is full.
// Input and output are small queues, so new chunks are taken while the
// divider works and results wait for pop. Write configuration only while
// the block is idle.
module mnemonic_word_index_encoder_unit
  import mwie_pkg::*;
#(
  parameter int CMD_DEPTH = CMD_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [INDEX_W-1:0] cfg_wdata,
  input  logic               in_push,
  input  in_item_t           in_data,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output out_item_t          out_data
);

  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_wr, cmd_rd;
  logic      res_push, res_full;
  out_item_t res;

  mwie_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_wr),
    .cmd_full  (cmd_full)
  );

  mwie_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wr),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rd),
    .empty (cmd_empty)
  );

  mwie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_rd),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  mwie_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

@@ rtl/mwie_fifo.sv @@
module mwie_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r   [DEPTH];
  logic [WIDTH-1:0] data_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;
  logic [CNT_W-1:0] wr_pos;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = data_r[0];
  assign wr_pos  = count_r - CNT_W'(do_pop);

  // shift queue: head always sits in entry 0
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_pop && (i < DEPTH - 1)) begin
        data_nxt[i] = data_r[(i < DEPTH - 1) ? i + 1 : i];
      end else begin
        data_nxt[i] = data_r[i];
      end
    end
    if (do_push) begin
      data_nxt[wr_pos[PTR_W-1:0]] = wdata;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      data_r[i] <= data_nxt[i];
    end
  end

endmodule

@@ rtl/mwie_front.sv @@
module mwie_front
  import mwie_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [INDEX_W-1:0] cfg_wdata,
  input  logic               in_push,
  input  in_item_t           in_data,
  output logic               in_full,
  output logic               cmd_push,
  output cmd_t               cmd,
  input  logic               cmd_full
);

  logic [INDEX_W-1:0] list_length_r;
  logic [WPC_W-1:0]   word_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_length_r <= LIST_LENGTH_RST;
      word_count_r  <= WORD_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIST_LENGTH: list_length_r <= cfg_wdata;
        CFG_WORD_COUNT:  word_count_r  <= cfg_wdata[WPC_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one; word count clamped to 1..MAX_WORDS
  always_comb begin
    cmd.chunk_word = in_data.chunk_word;
    cmd.chunk_last = in_data.chunk_last;
    cmd.modulus    = (list_length_r == '0) ? INDEX_W'(1) : list_length_r;
    if (word_count_r == '0) begin
      cmd.count = COUNT_W'(1);
    end else if (word_count_r > WPC_W'(MAX_WORDS)) begin
      cmd.count = COUNT_W'(MAX_WORDS);
    end else begin
      cmd.count = COUNT_W'(word_count_r);
    end
  end

  assign in_full  = cmd_full;
  assign cmd_push = in_push & ~cmd_full;

endmodule

@@ rtl/mwie_back.sv @@
module mwie_back
  import mwie_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  output logic      res_push,
  output out_item_t res,
  input  logic      res_full
);

  localparam int STEPS  = CHUNK_W / 2;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CHUNK_W-1:0] div_r, div_nxt;
  logic [INDEX_W-1:0] rem_r, rem_nxt;
  logic [INDEX_W-1:0] prev_r, prev_nxt;
  logic [INDEX_W-1:0] mod_r, mod_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [COUNT_W-1:0] word_r, word_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               last_r, last_nxt;

  logic [INDEX_W:0]   t1, t2;
  logic [INDEX_W:0]   sum;
  logic [INDEX_W-1:0] idx;
  logic               final_word;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [INDEX_W:0] div_step(input logic [INDEX_W-1:0] rem,
                                                input logic               bit_in,
                                                input logic [INDEX_W-1:0] m);
    logic [INDEX_W:0] sh;
    sh = {rem, bit_in};
    if (sh >= {1'b0, m}) begin
      div_step = {1'b1, INDEX_W'(sh - {1'b0, m})};
    end else begin
      div_step = {1'b0, sh[INDEX_W-1:0]};
    end
  endfunction

  always_comb begin
    state_nxt = state_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    prev_nxt  = prev_r;
    mod_nxt   = mod_r;
    count_nxt = count_r;
    word_nxt  = word_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;

    t1  = div_step(rem_r, div_r[CHUNK_W-1], mod_r);
    t2  = div_step(t1[INDEX_W-1:0], div_r[CHUNK_W-2], mod_r);
    // remainder and previous index both below the modulus
    sum = {1'b0, rem_r} + {1'b0, prev_r};
    idx = (sum >= {1'b0, mod_r}) ? INDEX_W'(sum - {1'b0, mod_r}) : sum[INDEX_W-1:0];
    final_word = (word_r + COUNT_W'(1) == count_r);

    res.word_index     = idx;
    res.last_of_chunk  = final_word;
    res.last_of_phrase = final_word & last_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          div_nxt   = cmd.chunk_word;
          rem_nxt   = '0;
          prev_nxt  = '0;
          mod_nxt   = cmd.modulus;
          count_nxt = cmd.count;
          last_nxt  = cmd.chunk_last;
          word_nxt  = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        div_nxt  = {div_r[CHUNK_W-3:0], t1[INDEX_W], t2[INDEX_W]};
        rem_nxt  = t2[INDEX_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // div_r now holds the quotient, the dividend of the next word
        if (!res_full) begin
          res_push = 1'b1;
          prev_nxt = idx;
          if (final_word) begin
            state_nxt = S_IDLE;
          end else begin
            word_nxt  = word_r + COUNT_W'(1);
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      word_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      word_r  <= word_nxt;
      step_r  <= step_nxt;
    end
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    prev_r  <= prev_nxt;
    mod_r   <= mod_nxt;
    count_r <= count_nxt;
    last_r  <= last_nxt;
  end

endmodule

@@ sim/mwie_checker.sv @@
`timescale 1ns / 100ps

module mwie_checker
  import mwie_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [INDEX_W-1:0] cfg_wdata,
  input  logic               in_push,
  input  logic               in_full,
  input  in_item_t           in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  out_item_t          out_data,
  output int                 mismatch_count,
  output int                 pending_results
);

  logic [INDEX_W-1:0] list_len;
  logic [WPC_W-1:0]   words_cfg;
  out_item_t          expected_words[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // Queue the indices one chunk should produce under the current registers.
  task automatic encode_chunk(input in_item_t chunk);
    longint unsigned modulus;
    longint unsigned divisor;
    longint unsigned quotient;
    longint unsigned prev_idx;
    longint unsigned idx;
    int              count;
    bit              beyond;
    bit              tail;
    out_item_t       word;
    modulus = (list_len == '0) ? 1 : longint'(list_len);
    count   = int'(words_cfg);
    if (count == 0)
      count = 1;
    if (count > MAX_WORDS)
      count = MAX_WORDS;
    divisor  = 1;
    beyond   = 1'b0;
    prev_idx = 0;
    for (int k = 0; k < count; k++) begin
      quotient = beyond ? 0 : longint'(chunk.chunk_word) / divisor;
      idx      = (quotient + prev_idx) % modulus;
      tail     = (k == count - 1);
      word.word_index     = idx[INDEX_W-1:0];
      word.last_of_chunk  = tail;
      word.last_of_phrase = tail && chunk.chunk_last;
      expected_words.push_back(word);
      prev_idx = idx;
      if (!beyond) begin
        divisor = divisor * modulus;
        // past 32 bits the quotient is zero for good
        if (divisor > 64'hFFFF_FFFF)
          beyond = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      list_len  = LIST_LENGTH_RST;
      words_cfg = WORD_COUNT_RST;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LIST_LENGTH: list_len  = cfg_wdata;
          CFG_WORD_COUNT:  words_cfg = cfg_wdata[WPC_W-1:0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        encode_chunk(in_data);
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: index %0d chunk_end %0b phrase_end %0b",
                     out_data.word_index, out_data.last_of_chunk, out_data.last_of_phrase);
        end else begin
          want = expected_words.pop_front();
          if (out_data.word_index !== want.word_index ||
              out_data.last_of_chunk !== want.last_of_chunk ||
              out_data.last_of_phrase !== want.last_of_phrase) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"result mismatch: expected index %0d chunk_end %0b phrase_end %0b,",
                        " got index %0d chunk_end %0b phrase_end %0b"},
                       want.word_index, want.last_of_chunk, want.last_of_phrase,
                       out_data.word_index, out_data.last_of_chunk,
                       out_data.last_of_phrase);
          end
        end
      end
    end
    pending_results = expected_words.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mwie_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [INDEX_W-1:0] cfg_wdata;
  logic               in_push;
  in_item_t           in_data;
  logic               in_full;
  logic               out_empty;
  logic               out_pop = 1'b0;
  out_item_t          out_data;

  int mismatch_count;
  int pending_results;
  int cycle_count = 0;
  int pop_hold = 0;
  bit steady = 1'b0;

  mnemonic_word_index_encoder_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  mwie_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data         (in_data),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short idles, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80)
      return $urandom_range(1, 4);
    return $urandom_range(10, 100);
  endfunction

  function automatic logic [CHUNK_W-1:0] random_chunk();
    case ($urandom_range(0, 5))
      0:       return CHUNK_W'($urandom_range(0, 255));
      1:       return 32'hFFFF_FFFF - CHUNK_W'($urandom_range(0, 255));
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return CHUNK_W'($urandom);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] random_list_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      return INDEX_W'($urandom_range(0, 1));
    if (pick < 25)
      return ($urandom_range(0, 1) != 0) ? 16'd2 : 16'hFFFF;
    if (pick < 50)
      return INDEX_W'($urandom_range(2, 100));
    return INDEX_W'($urandom_range(2, 65535));
  endfunction

  // receiver: stalls at random unless in a steady stretch
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop  <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 25)
        pop_hold <= idle_len();
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_chunk(input logic [CHUNK_W-1:0] word, input logic tail);
    int gap;
    in_push <= 1'b1;
    in_data <= {word, tail};
    do @(posedge clk); while (in_full);
    @(negedge clk);
    gap = (!steady && $urandom_range(0, 99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      in_data <= {CHUNK_W'($urandom), 1'($urandom)};
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic hold_until_drained();
    in_push <= 1'b0;
    while (pending_results != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [INDEX_W-1:0] list_length,
                               input logic [INDEX_W-1:0] words_raw,
                               input bit no_idle);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LIST_LENGTH;
    cfg_wdata <= list_length;
    @(negedge clk);
    cfg_index <= CFG_WORD_COUNT;
    cfg_wdata <= words_raw;
    @(negedge clk);
    cfg_we <= 1'b0;
    steady <= no_idle;
    @(negedge clk);
  endtask

  initial begin
    int n_items;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LIST_LENGTH;
    cfg_wdata = '0;
    in_push   = 1'b0;
    in_data   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: 1626 words, three per chunk
    send_chunk(32'h0000_0000, 1'b0);
    send_chunk(32'hFFFF_FFFF, 1'b1);
    send_chunk(32'h0000_0001, 1'b0);
    send_chunk(32'h8000_0000, 1'b1);
    send_chunk(32'hAAAA_AAAA, 1'b0);
    send_chunk(32'h5555_5555, 1'b1);

    // widest list, eight words: divisor runs past 32 bits; upper data bits ignored
    apply_setting(16'hFFFF, 16'hFFF8, 1'b0);
    send_chunk(32'hFFFF_FFFF, 1'b1);
    send_chunk(32'h0000_0000, 1'b0);
    send_chunk(32'h1234_5678, 1'b1);

    // zero list length acts as one; zero words acts as one
    apply_setting(16'h0000, 16'h0000, 1'b1);
    send_chunk(32'hDEAD_BEEF, 1'b1);
    send_chunk(32'h0000_0007, 1'b0);

    // list length one, word count above eight saturates
    apply_setting(16'h0001, 16'h0009, 1'b0);
    send_chunk(32'hFFFF_FFFF, 1'b1);
    send_chunk(32'h7FFF_FFFF, 1'b0);

    // smallest real list, largest raw word count
    apply_setting(16'h0002, 16'h000F, 1'b0);
    send_chunk(32'hFFFF_FFFF, 1'b1);
    send_chunk(32'h0000_00FF, 1'b0);

    apply_setting(16'h0002, 16'h0001, 1'b0);
    send_chunk(32'h0000_0003, 1'b1);
    send_chunk(32'hFFFF_FFFE, 1'b0);

    // random phases
    for (int phase = 0; phase < 8; phase++) begin
      apply_setting(random_list_length(),
                    {INDEX_W'($urandom_range(0, 4095)) << WPC_W} |
                      INDEX_W'($urandom_range(0, 15)),
                    (phase == 0) || ($urandom_range(0, 3) == 0));
      n_items = $urandom_range(15, 22);
      for (int i = 0; i < n_items; i++) begin
        if (phase == 3 && i == n_items / 2)
          hold_until_drained();
        send_chunk(random_chunk(), 1'($urandom_range(0, 1)));
      end
    end

    // back to the reset values
    apply_setting(LIST_LENGTH_RST, INDEX_W'(WORD_COUNT_RST), 1'b0);
    for (int i = 0; i < 8; i++)
      send_chunk(random_chunk(), 1'($urandom_range(0, 1)));

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mwie_pkg.sv
rtl/mwie_fifo.sv
rtl/mwie_front.sv
rtl/mwie_back.sv
rtl/mnemonic_word_index_encoder_unit.sv
sim/mwie_checker.sv
sim/tb_top.sv
